// ===== rtl/core/sbi_pkg.sv =====
// Shared types, codes and defaults for the sorted binary insert unit.
package sbi_pkg;

    localparam int STORE_DEPTH_DEF = 1024;

    localparam int POS_W   = 11;
    localparam int COUNT_W = 11;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 10;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic [INDEX_W-1:0]       read_index;
        logic signed [DATA_W-1:0] new_value;
        logic [CMD_W-1:0]         command;
    } sbi_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] read_data;
        logic [COUNT_W-1:0]       entry_count;
        logic [POS_W-1:0]         insert_position;
    } sbi_res_t;

endpackage

// ===== rtl/core/sbi_store.sv =====
// Sorted entry storage: one write port and one registered read port.
module sbi_store
    import sbi_pkg::*;
#(
    parameter int DEPTH  = STORE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0]        raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sbi_seq.sv =====
// Command sequencer: binary search, shift-up pass, indexed read, clear and fill count over the shared store port.
module sbi_seq
    import sbi_pkg::*;
#(
    parameter int DEPTH  = STORE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int CNT_W  = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  sbi_req_t                 req,
    output logic                     ready,
    output logic                     done,
    input  logic                     take,
    output sbi_res_t                 res,
    output logic                     ram_we,
    output logic [ADDR_W-1:0]        ram_waddr,
    output logic signed [DATA_W-1:0] ram_wdata,
    output logic [ADDR_W-1:0]        ram_raddr,
    input  logic signed [DATA_W-1:0] ram_rdata
);

    localparam int OW = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int IW = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_SHIFT,
        S_SHEND,
        S_PUT,
        S_RDWAIT,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [ADDR_W-1:0]        src_reg, src_next;
    logic [ADDR_W-1:0]        pend_addr_reg, pend_addr_next;
    logic                     pend_reg, pend_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    sbi_res_t                 res_reg, res_next;

    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_p1;
    logic [IW-1:0]    idx_ext;
    logic [IW-1:0]    cnt_iext;
    logic [OW-1:0]    cnt_oext;
    logic [OW-1:0]    cnt_p1_oext;
    logic [OW-1:0]    lo_oext;

    assign mid_calc    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign cnt_m1      = cnt_reg - 1'b1;
    assign cnt_p1      = cnt_reg + 1'b1;
    assign idx_ext     = IW'(req.read_index);
    assign cnt_iext    = IW'(cnt_reg);
    assign cnt_oext    = OW'(cnt_reg);
    assign cnt_p1_oext = OW'(cnt_p1);
    assign lo_oext     = OW'(lo_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        src_next       = src_reg;
        pend_addr_next = pend_addr_reg;
        pend_next      = pend_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = src_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next.insert_position = '0;
                    res_next.entry_count     = cnt_oext[COUNT_W-1:0];
                    res_next.read_data       = '0;
                    res_next.status          = ST_OK;
                    val_next                 = req.new_value;
                    case (req.command)
                        CMD_INSERT:
                        begin
                            if (cnt_reg >= CNT_W'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = cnt_reg;
                                state_next = S_SRCH;
                            end
                        end
                        CMD_READ:
                        begin
                            if (idx_ext >= cnt_iext)
                            begin
                                res_next.status = ST_BAD_INDEX;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                ram_raddr  = idx_ext[ADDR_W-1:0];
                                state_next = S_RDWAIT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next             = '0;
                            res_next.entry_count = '0;
                            state_next           = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_raddr  = mid_calc[ADDR_W-1:0];
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end
                else if (cnt_reg > lo_reg)
                begin
                    src_next   = cnt_m1[ADDR_W-1:0];
                    pend_next  = 1'b0;
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_CMP:
            begin
                if (ram_rdata < val_reg)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_SHIFT:
            begin
                // Read one entry per cycle while the previous one lands one place up.
                ram_raddr      = src_reg;
                ram_we         = pend_reg;
                pend_next      = 1'b1;
                pend_addr_next = src_reg + 1'b1;
                if (src_reg == lo_reg[ADDR_W-1:0])
                begin
                    state_next = S_SHEND;
                end
                else
                begin
                    src_next = src_reg - 1'b1;
                end
            end
            S_SHEND:
            begin
                ram_we     = 1'b1;
                pend_next  = 1'b0;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                ram_we                   = 1'b1;
                ram_waddr                = lo_reg[ADDR_W-1:0];
                ram_wdata                = val_reg;
                cnt_next                 = cnt_p1;
                res_next.insert_position = lo_oext[POS_W-1:0];
                res_next.entry_count     = cnt_p1_oext[COUNT_W-1:0];
                state_next               = S_DONE;
            end
            S_RDWAIT:
            begin
                res_next.read_data = ram_rdata;
                state_next         = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        src_reg       <= src_next;
        pend_addr_reg <= pend_addr_next;
        val_reg       <= val_next;
        res_reg       <= res_next;
    end

    assign ready = (state_reg == S_IDLE);
    assign done  = (state_reg == S_DONE);
    assign res   = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("fill count exceeds store depth");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH || state_reg == S_CMP) |-> (lo_reg <= hi_reg && hi_reg <= cnt_reg))
        else $error("search bounds out of order");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> (ADDR_W'(src_reg) >= lo_reg[ADDR_W-1:0] && cnt_reg > lo_reg))
        else $error("shift pointer below insert position");

    a_put_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUT |=> (state_reg == S_DONE && cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("insert did not advance fill count");

endmodule

// ===== rtl/core/sorted_binary_insert_unit.sv =====
// Top level of the sorted binary insert unit: stream ports, result register and core wiring.
//
// The unit keeps an ascending store of signed 32-bit values and serves one command at a
// time over a single memory with one write and one registered read port. An insert
// binary-searches the store, with a search state and a compare state per probe, then moves
// every entry at or above the insert position up one place at one entry per cycle, and
// writes the new value. The input side is not ready while a command is in progress; a
// finished result moves into the output register once that register is free, so the next
// command can start while the result waits there. The fill count bounds every read, so
// the store needs no clearing pass after reset.
module sorted_binary_insert_unit
    import sbi_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // command[1:0], new_value[33:2], read_index[43:34], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // insert_position[10:0], entry_count[21:11],
                                  // read_data[53:22], status[55:54]
);

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

    sbi_req_t                 req;
    sbi_res_t                 res;
    logic                     seq_ready;
    logic                     seq_done;
    logic                     take;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic signed [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic signed [DATA_W-1:0] ram_rdata;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [55:0]              m_tdata_reg, m_tdata_next;

    assign req      = sbi_req_t'(s_tdata[43:0]);
    assign s_tready = seq_ready;
    assign take     = !m_tvalid_reg || m_tready;

    sbi_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sbi_seq #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && seq_ready),
        .req       (req),
        .ready     (seq_ready),
        .done      (seq_done),
        .take      (take),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (take)
        begin
            m_tvalid_next = seq_done;
            if (seq_done)
            begin
                m_tdata_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
